>>> rtl/pgld_pkg.sv
// Shared constants and types for the point grid local deviation block.
package pgld_pkg;

  localparam int MaxWidth    = 2048;
  localparam int HeightLimit = 2048;
  localparam int ColBits     = $clog2(MaxWidth);
  localparam int RowBits     = $clog2(HeightLimit);
  localparam int EffWBits    = ColBits + 1;
  localparam int EffHBits    = RowBits + 1;
  localparam int CfgBits     = 12;
  localparam int CfgIdxBits  = 2;
  localparam int FieldBits   = 16;
  localparam int CoordBits   = 16;

  // Window arithmetic. A 3x3 window holds at most nine present points.
  localparam int NBits       = 4;
  localparam int SumBits     = CoordBits + NBits;
  localparam int DevBits     = 4;
  localparam int SqBits      = 7;
  localparam int NumBits     = 8;
  localparam int NumSumBits  = 10;
  localparam int QBits       = 8;
  localparam int BumpBits    = 9;
  localparam int BumpMax     = 256;
  localparam int DivSteps    = QBits;
  localparam int StepBits    = $clog2(DivSteps);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgGridWidth  = 2'd0,
    CfgGridHeight = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                 valid;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
  } cell_t;

  typedef struct packed {
    cell_t older;
    cell_t newer;
  } line_t;

  typedef struct packed {
    logic                 present;
    logic [FieldBits-1:0] coord_x;
    logic [FieldBits-1:0] coord_y;
    logic [FieldBits-1:0] coord_z;
  } in_req_t;

  typedef struct packed {
    logic [BumpBits-1:0] bump;
    logic                row_end;
    logic                frame_end;
  } out_rsp_t;

  typedef struct packed {
    logic                valid;
    logic [BumpBits-1:0] bump;
  } dev_res_t;

endpackage

>>> rtl/pgld_line_mem.sv
// Line memory holding the two previous grid rows, one entry per column.
module pgld_line_mem
  import pgld_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ColBits-1:0] waddr_i,
  input  line_t              wdata_i,
  input  logic               re_i,
  input  logic [ColBits-1:0] raddr_i,
  output line_t              rdata_o
);

  line_t mem_q [MaxWidth];
  line_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pgld_dev_unit.sv
// Deviation unit: window sums, exact squared distance and a bit-serial divider.
module pgld_dev_unit
  import pgld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cell_t [8:0] win_i,
  output dev_res_t    res_o
);

  typedef enum logic [4:0] {
    DIdle   = 5'b00001,
    DDiff   = 5'b00010,
    DSquare = 5'b00100,
    DDiv    = 5'b01000,
    DDone   = 5'b10000
  } dev_state_e;

  dev_state_e state_q, state_d;

  logic [NBits-1:0]     n_q;
  logic [SumBits-1:0]   sum_q [3];
  logic [CoordBits-1:0] ctr_q [3];
  logic [DevBits-1:0]   d_q [3];
  logic                 big_q;
  logic [SqBits-1:0]    nsq_q;
  logic [NumBits-1:0]   rem_q;
  logic [QBits-1:0]     quo_q;
  logic [StepBits-1:0]  step_q;
  logic [BumpBits-1:0]  bump_q;

  // Combinational window sums, registered in every idle cycle; the start cycle's sums are kept.
  logic [NBits-1:0]   n_c;
  logic [SumBits-1:0] sx_c, sy_c, sz_c;

  always_comb begin
    n_c  = '0;
    sx_c = '0;
    sy_c = '0;
    sz_c = '0;
    for (int i = 0; i < 9; i++) begin
      if (win_i[i].valid) begin
        n_c  = n_c + NBits'(1);
        sx_c = sx_c + SumBits'(win_i[i].x);
        sy_c = sy_c + SumBits'(win_i[i].y);
        sz_c = sz_c + SumBits'(win_i[i].z);
      end
    end
  end

  // Absolute differences |S - n*c|; a difference of n or more saturates the result.
  logic [SumBits-1:0] diff_c [3];
  logic [SumBits-1:0] nc_c [3];
  logic               big_c;

  always_comb begin
    big_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      nc_c[k] = SumBits'(n_q) * SumBits'(ctr_q[k]);
      if (sum_q[k] >= nc_c[k]) begin
        diff_c[k] = sum_q[k] - nc_c[k];
      end else begin
        diff_c[k] = nc_c[k] - sum_q[k];
      end
      if (diff_c[k] >= SumBits'(n_q)) begin
        big_c = 1'b1;
      end
    end
  end

  logic [NumSumBits-1:0] num_c;

  always_comb begin
    num_c = '0;
    for (int k = 0; k < 3; k++) begin
      num_c = num_c + NumSumBits'(d_q[k]) * NumSumBits'(d_q[k]);
    end
  end

  // One quotient bit of floor(256*num/n^2) per cycle.
  logic [NumBits:0]   shifted_c;
  logic [NumBits-1:0] rem_c;
  logic [QBits-1:0]   quo_c;

  always_comb begin
    shifted_c = {rem_q, 1'b0};
    if (shifted_c >= (NumBits + 1)'(nsq_q)) begin
      rem_c = NumBits'(shifted_c - (NumBits + 1)'(nsq_q));
      quo_c = {quo_q[QBits-2:0], 1'b1};
    end else begin
      rem_c = NumBits'(shifted_c);
      quo_c = {quo_q[QBits-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIdle: begin
        if (start_i) begin
          state_d = win_i[4].valid ? DDiff : DDone;
        end
      end
      DDiff:   state_d = DSquare;
      DSquare: begin
        if (big_q || (num_c >= NumSumBits'(nsq_q))) begin
          state_d = DDone;
        end else begin
          state_d = DDiv;
        end
      end
      DDiv: begin
        if (step_q == StepBits'(DivSteps - 1)) begin
          state_d = DDone;
        end
      end
      DDone:   state_d = DIdle;
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIdle: begin
        n_q      <= n_c;
        sum_q[0] <= sx_c;
        sum_q[1] <= sy_c;
        sum_q[2] <= sz_c;
        ctr_q[0] <= win_i[4].x;
        ctr_q[1] <= win_i[4].y;
        ctr_q[2] <= win_i[4].z;
        bump_q   <= '0;
      end
      DDiff: begin
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= diff_c[k][DevBits-1:0];
        end
        big_q <= big_c;
        nsq_q <= SqBits'(n_q) * SqBits'(n_q);
      end
      DSquare: begin
        rem_q  <= num_c[NumBits-1:0];
        quo_q  <= '0;
        step_q <= '0;
        bump_q <= BumpBits'(BumpMax);
      end
      DDiv: begin
        rem_q  <= rem_c;
        quo_q  <= quo_c;
        step_q <= step_q + StepBits'(1);
        bump_q <= BumpBits'(quo_c);
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid = (state_q == DDone);
  assign res_o.bump  = bump_q;

endmodule

>>> rtl/point_grid_local_deviation.sv
// Top level of the point grid local deviation block: counters, window, sequencing.
// An interior request waits longest for its result when it runs the 8-step divider;
// a saturated result or an absent centre is shorter.
// Requests are taken one at a time: a new request waits until the last is done, and
// the line memory read and the divider bound the rate.
// Reset: counters, handshake and sequencer clear; grid size returns to 512 by 512.
// The line memory and window are not cleared; unwritten entries never reach a result.
module point_grid_local_deviation
  import pgld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_rsp_o
);

  // The sequencer walks each request through the line memory read, the window
  // update and, for interior positions, the deviation unit.
  typedef enum logic [4:0] {
    TIdle  = 5'b00001,
    TRead  = 5'b00010,
    TStart = 5'b00100,
    TCalc  = 5'b01000,
    TOut   = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [CfgBits-1:0]  width_q, height_q;
  logic [ColBits-1:0]  col_q;
  logic [RowBits-1:0]  row_q;
  logic [EffWBits-1:0] eff_w;
  logic [EffHBits-1:0] eff_h;

  cell_t               cur_q;
  logic [ColBits-1:0]  addr_q;
  logic                produce_q, row_end_q, frame_end_q;
  cell_t [8:0]         win_q;
  logic [BumpBits-1:0] bump_q;
  logic                out_valid_q;
  out_rsp_t            out_q;

  line_t               rd_line;
  line_t               wr_line;
  dev_res_t            dev_res;

  // Effective grid size: the registers clamped to the supported range.
  always_comb begin
    logic [31:0] w_ext, h_ext;
    w_ext = 32'(width_q);
    h_ext = 32'(height_q);
    if (w_ext < 32'd3) w_ext = 32'd3;
    if (w_ext > 32'(MaxWidth)) w_ext = 32'(MaxWidth);
    if (h_ext < 32'd3) h_ext = 32'd3;
    if (h_ext > 32'(HeightLimit)) h_ext = 32'(HeightLimit);
    eff_w = EffWBits'(w_ext);
    eff_h = EffHBits'(h_ext);
  end

  logic in_acc, col_last, row_last, out_free, cfg_hit;

  assign in_stall_o = (state_q != TIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign col_last   = ({1'b0, col_q} == eff_w - EffWBits'(1));
  assign row_last   = ({1'b0, row_q} == eff_h - EffHBits'(1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == CfgGridWidth) ||
                                   (cfg_idx_i == CfgGridHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgBits'(512);
      height_q <= CfgBits'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridWidth:  width_q  <= cfg_data_i;
        CfgGridHeight: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Position of the next request; a width or height write starts a new grid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RowBits'(1);
      end else begin
        col_q <= col_q + ColBits'(1);
      end
    end
  end

  // Request capture: cell, column, end flags and whether it closes an interior window.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q.valid <= in_req_i.present;
      cur_q.x     <= in_req_i.coord_x[CoordBits-1:0];
      cur_q.y     <= in_req_i.coord_y[CoordBits-1:0];
      cur_q.z     <= in_req_i.coord_z[CoordBits-1:0];
      addr_q      <= col_q;
      produce_q   <= (row_q >= RowBits'(2)) && (col_q >= ColBits'(2));
      row_end_q   <= col_last;
      frame_end_q <= col_last && row_last;
    end
  end

  // Each memory entry holds rows r-2 and r-1 of one column; the read issues at
  // acceptance and the write-back of {r-1, r} follows in the next cycle, so a
  // request is fully done with its entry before the next one can read.
  assign wr_line.older = rd_line.newer;
  assign wr_line.newer = cur_q;

  pgld_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == TRead),
    .waddr_i (addr_q),
    .wdata_i (wr_line),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (rd_line)
  );

  // The 3x3 window, index row*3+column, column 2 newest. It shifts once per request.
  always_ff @(posedge clk_i) begin
    if (state_q == TRead) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]     <= win_q[i*3 + 1];
        win_q[i*3 + 1] <= win_q[i*3 + 2];
      end
      win_q[2] <= rd_line.older;
      win_q[5] <= rd_line.newer;
      win_q[8] <= cur_q;
    end
  end

  pgld_dev_unit u_dev_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == TStart),
    .win_i   (win_q),
    .res_o   (dev_res)
  );

  always_ff @(posedge clk_i) begin
    if ((state_q == TCalc) && dev_res.valid) begin
      bump_q <= dev_res.bump;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TIdle:   if (in_acc) state_d = TRead;
      TRead:   state_d = produce_q ? TStart : TIdle;
      TStart:  state_d = TCalc;
      TCalc:   if (dev_res.valid) state_d = TOut;
      TOut:    if (out_free) state_d = TIdle;
      default: state_d = TIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: the result waits here while the sequencer takes new requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == TOut) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == TOut) && out_free) begin
      out_q.bump      <= bump_q;
      out_q.row_end   <= row_end_q;
      out_q.frame_end <= frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < eff_w) && ({1'b0, row_q} < eff_h))
    else $error("grid position outside the effective grid");

  a_bump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.bump <= BumpBits'(BumpMax)))
    else $error("deviation above saturation value");

  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.frame_end) |-> out_rsp_o.row_end)
    else $error("frame end without row end");
`endif

endmodule

>>> tb/point_grid_deviation_checker.sv
// Checker that predicts each local deviation result of the point grid and compares it.
`timescale 1ns / 100ps

module point_grid_deviation_checker
  import pgld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_req_t               in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_rsp_t              out_rsp_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // Rows r-2 and r-1 of the grid, and the 3x3 neighborhood ([row][column], column 2 newest).
  cell_t              two_back_row [MaxWidth];
  cell_t              one_back_row [MaxWidth];
  cell_t              nbhd [3][3];
  logic [CfgBits-1:0] width_reg;
  logic [CfgBits-1:0] height_reg;
  int unsigned        col_pos;
  int unsigned        row_pos;
  out_rsp_t           expected_bumps [$];
  out_rsp_t           want_rsp;
  int                 errors = 0;

  function automatic int unsigned clamp_size(logic [CfgBits-1:0] v, int unsigned upper);
    if (v < 3) return 3;
    if (v > upper) return upper;
    return v;
  endfunction

  // Exact integer form: num = sum of (S - n*c)^2, bump = floor(256*num/n^2), capped at 256.
  function automatic logic [BumpBits-1:0] nbhd_bump();
    longint unsigned total [3];
    longint unsigned ctr [3];
    longint unsigned n;
    longint unsigned num;
    longint unsigned nc;
    longint unsigned diff;
    if (!nbhd[1][1].valid) return '0;
    n = 0;
    num = 0;
    for (int k = 0; k < 3; k++) total[k] = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (nbhd[i][j].valid) begin
          n++;
          total[0] += nbhd[i][j].x;
          total[1] += nbhd[i][j].y;
          total[2] += nbhd[i][j].z;
        end
      end
    end
    ctr[0] = nbhd[1][1].x;
    ctr[1] = nbhd[1][1].y;
    ctr[2] = nbhd[1][1].z;
    for (int k = 0; k < 3; k++) begin
      nc = n * ctr[k];
      diff = (total[k] >= nc) ? total[k] - nc : nc - total[k];
      num += diff * diff;
    end
    if (num < n * n) return BumpBits'((num * 256) / (n * n));
    return BumpBits'(BumpMax);
  endfunction

  task automatic take_point(in_req_t req);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    cell_t       cur;
    cell_t       upper_cell;
    cell_t       mid_cell;
    out_rsp_t    rsp;
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, HeightLimit);
    col = (col_pos >= w) ? 0 : col_pos;
    row = (row_pos >= h) ? 0 : row_pos;
    cur.valid = req.present;
    cur.x = req.coord_x;
    cur.y = req.coord_y;
    cur.z = req.coord_z;
    upper_cell = two_back_row[col];
    mid_cell = one_back_row[col];
    two_back_row[col] = mid_cell;
    one_back_row[col] = cur;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = upper_cell;
    nbhd[1][2] = mid_cell;
    nbhd[2][2] = cur;
    if (row >= 2 && col >= 2) begin
      rsp.bump = nbhd_bump();
      rsp.row_end = (col == w - 1);
      rsp.frame_end = (col == w - 1) && (row == h - 1);
      expected_bumps.push_back(rsp);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  task automatic compare_field(string name, logic [BumpBits-1:0] want, logic [BumpBits-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = 12'd512;
      height_reg = 12'd512;
      col_pos = 0;
      row_pos = 0;
      expected_bumps.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGridWidth: begin
            width_reg = cfg_data_i;
            col_pos = 0;
            row_pos = 0;
          end
          CfgGridHeight: begin
            height_reg = cfg_data_i;
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_bumps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual bump %0d row_end %0b frame_end %0b",
                   $time, out_rsp_i.bump, out_rsp_i.row_end, out_rsp_i.frame_end);
        end else begin
          want_rsp = expected_bumps.pop_front();
          compare_field("bump", want_rsp.bump, out_rsp_i.bump);
          compare_field("row_end", want_rsp.row_end, out_rsp_i.row_end);
          compare_field("frame_end", want_rsp.frame_end, out_rsp_i.frame_end);
        end
      end
      if (in_valid_i && !in_stall_i) take_point(in_req_i);
      fail_count_o <= errors;
      pending_o <= expected_bumps.size();
    end
  end

endmodule

>>> tb/point_grid_local_deviation_tb.sv
// Testbench top for the point grid local deviation block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module point_grid_local_deviation_tb;
  import pgld_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned RandomPoints  = 430;
  localparam int unsigned BigGridPoints = 48;

  // Register indexes past the end of the register list; writes there must change nothing.
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = CfgGridWidth;
  logic [CfgBits-1:0]    cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_rsp;
  int                    fail_count;
  int                    pending;

  // Shared between the request driver and the result sink: calm turns off random idling on
  // both sides, and each increment of hold_asks asks the sink for one long hold-off.
  bit          calm = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned cycle_count = 0;

  // Shape of the random points in the current phase: a common base per axis plus a small
  // jitter keeps most deviations below one unit, so the fractional results get exercised.
  int unsigned base_x;
  int unsigned base_y;
  int unsigned base_z;
  int unsigned jitter;
  int unsigned present_pct;

  point_grid_local_deviation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  point_grid_deviation_checker deviation_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result sink. It normally stalls about 15 percent of the time. On request it holds off
  // for a long stretch so the block backs up and stalls its request side.
  initial begin
    int unsigned hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 15);
      end
    end
  end

  function automatic in_req_t point(logic present, int unsigned x, int unsigned y,
                                    int unsigned z);
    in_req_t p;
    p.present = present;
    p.coord_x = FieldBits'(x);
    p.coord_y = FieldBits'(y);
    p.coord_z = FieldBits'(z);
    return p;
  endfunction

  // Mostly clustered points; some fully random and some at the coordinate extremes, which
  // mostly drive the result into saturation.
  function automatic in_req_t random_point();
    in_req_t     p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    p.present = ($urandom_range(0, 99) < present_pct);
    if (pick < 8) begin
      p.coord_x = FieldBits'($urandom);
      p.coord_y = FieldBits'($urandom);
      p.coord_z = FieldBits'($urandom);
    end else if (pick < 11) begin
      p.coord_x = ($urandom_range(0, 1) != 0) ? '1 : '0;
      p.coord_y = ($urandom_range(0, 1) != 0) ? '1 : '0;
      p.coord_z = ($urandom_range(0, 1) != 0) ? '1 : '0;
    end else begin
      p.coord_x = FieldBits'(base_x + $urandom_range(0, jitter));
      p.coord_y = FieldBits'(base_y + $urandom_range(0, jitter));
      p.coord_z = FieldBits'(base_z + $urandom_range(0, jitter));
    end
    return p;
  endfunction

  // Offers one request and waits until it is taken. Valid stays high into the next request
  // unless a random gap is drawn, so back-to-back requests keep a single assignment per step.
  task automatic send_point(in_req_t p);
    in_valid <= 1'b1;
    in_req <= p;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic feed(int unsigned count);
    repeat (count) send_point(random_point());
  endtask

  // Stops offering and waits for every predicted result. Border requests give no result, so
  // a few more cycles let the block finish the last one before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(logic [CfgBits-1:0] w, logic [CfgBits-1:0] h);
    write_reg(CfgGridWidth, w);
    write_reg(CfgGridHeight, h);
  endtask

  task automatic shape_points(int unsigned spread, int unsigned pct);
    jitter = spread;
    present_pct = pct;
    base_x = $urandom_range(0, 65535 - spread);
    base_y = $urandom_range(0, 65535 - spread);
    base_z = $urandom_range(0, 65535 - spread);
  endtask

  initial begin
    int unsigned phase;
    int unsigned fed;
    int unsigned count;
    logic [CfgBits-1:0] w;
    logic [CfgBits-1:0] h;
    shape_points(1, 90);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest grid, one result. Points sit at or next to the coordinate extremes; the first
    // corner is absent and the last one is one step off in x, so eight points give a squared
    // deviation of 1/64 and the result is a small fraction of full scale, with both end flags.
    set_grid(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 0) begin
        send_point(point(1'b0, 0, 65535, 0));
      end else if (i == 8) begin
        send_point(point(1'b1, 65535, 0, 65535));
      end else begin
        send_point(point(1'b1, 65534, 0, 65535));
      end
    end
    drain();

    // Four columns by three rows, two results. The first centre is absent; the second is the
    // only present point of its neighborhood, while the absent points carry far coordinates
    // that must not leak into the mean.
    write_reg(CfgGridWidth, 12'd4);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) begin
        send_point(point(1'b0, 100, 200, 300));
      end else if (i == 6) begin
        send_point(point(1'b1, 100, 200, 300));
      end else begin
        send_point(point(1'b0, 65535, 65535, 65535));
      end
    end
    drain();

    // Random phases on small grids, some with sizes below the minimum. A phase often runs past
    // one grid into the next and usually stops mid-grid, so the next register write must
    // restart the position counters.
    phase = 0;
    fed = 0;
    while (fed < RandomPoints) begin
      drain();
      w = ($urandom_range(0, 7) == 0) ? CfgBits'($urandom_range(0, 2))
                                      : CfgBits'($urandom_range(3, 10));
      h = ($urandom_range(0, 7) == 0) ? CfgBits'($urandom_range(0, 2))
                                      : CfgBits'($urandom_range(3, 6));
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CfgGridWidth, w);
        end else begin
          write_reg(CfgGridHeight, h);
        end
      end else begin
        set_grid(w, h);
      end
      shape_points($urandom_range(0, 3), $urandom_range(60, 100));
      count = (phase == 1 || phase == 2) ? 90 : $urandom_range(10, 90);
      // The second phase runs with no idling on either side.
      calm <= (phase == 1);
      if (phase == 2) begin
        // Halfway through, the sink holds off while requests keep coming.
        feed(count / 2);
        hold_asks <= hold_asks + 1;
        feed(count - count / 2);
      end else if (phase == 3) begin
        // Halfway through, the sender pauses until all results are in, then writes the
        // unmapped register indexes; the grid position must carry on undisturbed.
        feed(count / 2);
        drain();
        write_reg(CfgSpareLo, 12'($urandom));
        write_reg(CfgSpareHi, 12'($urandom));
        feed(count - count / 2);
      end else begin
        feed(count);
      end
      fed += count;
      phase++;
    end

    // Widest rows: an oversized width clamps to the line memory size, so the start of the
    // first row must run on without wrapping and give no result.
    drain();
    set_grid(12'hFFF, 12'd3);
    shape_points(1, 90);
    feed(BigGridPoints);

    // Tallest grid: an undersized width clamps to three columns and an oversized height to
    // the row limit, so the first rows go by with no frame end.
    drain();
    set_grid(12'd1, 12'hFFF);
    shape_points(2, 85);
    feed(BigGridPoints);

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
